/* rtl/core/atmb_pkg.sv */
// ----------------------------------------------------------------------------
// Affine matrix builder package
// Shared constants, tables and the CORDIC state type.
// ----------------------------------------------------------------------------
package atmb_pkg;

  localparam int FracBits    = 16;
  localparam int CordicSteps = 16;
  localparam int ValW        = 32;
  localparam int AccW        = 34;

  localparam logic [1:0] ModeTranslate = 2'd0;
  localparam logic [1:0] ModeScale     = 2'd1;
  localparam logic [1:0] ModeRotate    = 2'd2;

  localparam logic signed [AccW-1:0] GainQ30  = 34'sd652032874;
  localparam logic [31:0]            InvTwoPi = 32'd683565276;
  localparam logic [31:0]            PiQ30    = 32'd3373259426;
  localparam logic signed [31:0]     OneVal   = 32'sd1 <<< FracBits;

  localparam logic [29:0] AtanTab [24] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

  typedef struct packed {
    logic signed [AccW-1:0] x;
    logic signed [AccW-1:0] y;
    logic signed [AccW-1:0] z;
  } cordic_t;

endpackage

/* rtl/core/affine_transform_matrix_builder_unit.sv */
// ----------------------------------------------------------------------------
// Affine transform matrix builder
// Builds the 3x3 part and translation row of an affine matrix per item.
// ----------------------------------------------------------------------------
// One item enters per cycle while the result side is ready; the pipeline depth
// is set by the phase multiply stages, one CORDIC step per stage for all
// three angles in parallel, two matrix products and the output register.
// The block stalls as a whole when the result side is not ready.
module affine_transform_matrix_builder_unit import atmb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,  // mode[1:0]
  input  logic [95:0]  s_axis_tdata,  // x[31:0], y[63:32], z[95:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [383:0] m_axis_tdata   // r00,r01,r02,r10,r11,r12,r20,r21,r22,tx,ty,tz
);

  localparam int NS = CordicSteps;
  localparam int D  = NS + 7;

  logic adv;
  logic [D-1:0] vld_q;
  assign adv = m_axis_tready | ~m_axis_tvalid;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[D-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[D-2:0], s_axis_tvalid};
    end
  end

  // Input fields travel alongside the pipeline.
  logic [97:0] in_w;
  logic [97:0] pass_q [D];
  assign in_w = {s_axis_tdata, s_axis_tuser};
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pass_q[0] <= in_w;
      for (int i = 1; i < D; i++) pass_q[i] <= pass_q[i-1];
    end
  end

  // Stage 0: phase multiply.
  logic signed [63:0] prod_q [3];
  logic [31:0] ph_w [3];
  logic [1:0]  quad_q [3][NS+2];
  logic [29:0] resid_w [3];
  logic [61:0] rad_q [3];
  cordic_t     cs_q [3][NS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        prod_q[a] <= $signed(in_w[2+32*a +: 32]) * $signed({1'b0, InvTwoPi});
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ph_w[a]    = prod_q[a][FracBits +: 32];
      resid_w[a] = ph_w[a][29:0];
    end
  end

  // Stage 1: residual to radians.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        rad_q[a]     <= resid_w[a] * PiQ30;
        quad_q[a][0] <= ph_w[a][31:30];
      end
    end
  end

  // Stage 2: CORDIC seed, then one step per stage.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        cs_q[a][0].x <= GainQ30;
        cs_q[a][0].y <= '0;
        cs_q[a][0].z <= AccW'(rad_q[a][61:31]);
        quad_q[a][1] <= quad_q[a][0];
        for (int i = 0; i < NS; i++) begin
          quad_q[a][i+2] <= quad_q[a][i+1];
          if (!cs_q[a][i].z[AccW-1]) begin
            cs_q[a][i+1].x <= cs_q[a][i].x - (cs_q[a][i].y >>> i);
            cs_q[a][i+1].y <= cs_q[a][i].y + (cs_q[a][i].x >>> i);
            cs_q[a][i+1].z <= cs_q[a][i].z - AccW'(AtanTab[i]);
          end else begin
            cs_q[a][i+1].x <= cs_q[a][i].x + (cs_q[a][i].y >>> i);
            cs_q[a][i+1].y <= cs_q[a][i].y - (cs_q[a][i].x >>> i);
            cs_q[a][i+1].z <= cs_q[a][i].z + AccW'(AtanTab[i]);
          end
        end
      end
    end
  end

  // Quadrant fold and rounding, then Rx*Ry.
  logic signed [AccW-1:0] c_w [3], s_w [3];
  logic signed [ValW-1:0] sv_w [3], cv_w [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      case (quad_q[a][NS+1])
        2'd0:    begin c_w[a] = cs_q[a][NS].x;  s_w[a] = cs_q[a][NS].y;  end
        2'd1:    begin c_w[a] = -cs_q[a][NS].y; s_w[a] = cs_q[a][NS].x;  end
        2'd2:    begin c_w[a] = -cs_q[a][NS].x; s_w[a] = -cs_q[a][NS].y; end
        default: begin c_w[a] = cs_q[a][NS].y;  s_w[a] = -cs_q[a][NS].x; end
      endcase
      cv_w[a] = ValW'((c_w[a] + (AccW'(1) <<< (29 - FracBits))) >>> (30 - FracBits));
      sv_w[a] = ValW'((s_w[a] + (AccW'(1) <<< (29 - FracBits))) >>> (30 - FracBits));
    end
  end

  logic signed [ValW-1:0] sc_q [6];  // cx sx cy sy cz sz
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        sc_q[2*a]   <= cv_w[a];
        sc_q[2*a+1] <= sv_w[a];
      end
    end
  end

  function automatic logic signed [ValW-1:0] rnd(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + (66'sd1 <<< (FracBits - 1))) >>> FracBits;
    return t[ValW-1:0];
  endfunction

  // T = Rx*Ry: [cy 0 -sy; sx*sy cx sx*cy; cx*sy -sx cx*cy]
  logic signed [63:0] p_q [4];
  logic signed [ValW-1:0] cx1_q, sx1_q, cy1_q, sy1_q, cz1_q, sz1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= sc_q[1] * sc_q[3];
      p_q[1] <= sc_q[1] * sc_q[2];
      p_q[2] <= sc_q[0] * sc_q[3];
      p_q[3] <= sc_q[0] * sc_q[2];
      cx1_q <= sc_q[0]; sx1_q <= sc_q[1]; cy1_q <= sc_q[2];
      sy1_q <= sc_q[3]; cz1_q <= sc_q[4]; sz1_q <= sc_q[5];
    end
  end

  // T rows; entries that are plain copies or negations are taken without a product.
  logic signed [ValW-1:0] t_w [9];
  always_comb begin
    t_w[0] = cy1_q; t_w[1] = '0;            t_w[2] = -sy1_q;
    t_w[3] = rnd(66'(p_q[0])); t_w[4] = cx1_q; t_w[5] = rnd(66'(p_q[1]));
    t_w[6] = rnd(66'(p_q[2])); t_w[7] = -sx1_q; t_w[8] = rnd(66'(p_q[3]));
  end

  // M = T*Rz: col0 = t0*cz - t1*sz, col1 = t0*sz + t1*cz, col2 = t2.
  logic signed [63:0] q_q [12];
  logic signed [ValW-1:0] tc2_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        q_q[4*r]   <= t_w[3*r]   * cz1_q;
        q_q[4*r+1] <= t_w[3*r+1] * sz1_q;
        q_q[4*r+2] <= t_w[3*r]   * sz1_q;
        q_q[4*r+3] <= t_w[3*r+1] * cz1_q;
        tc2_q[r]   <= t_w[3*r+2];
      end
    end
  end

  logic signed [ValW-1:0] m_w [9];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      m_w[3*r]   = rnd(66'(q_q[4*r]) - 66'(q_q[4*r+1]));
      m_w[3*r+1] = rnd(66'(q_q[4*r+2]) + 66'(q_q[4*r+3]));
      m_w[3*r+2] = tc2_q[r];
    end
  end

  // Output register with mode selection.
  logic [97:0] fin_w;
  logic [383:0] out_d, out_q;
  assign fin_w = pass_q[D-2];
  always_comb begin
    out_d = '0;
    for (int k = 0; k < 3; k++) out_d[32*(4*k) +: 32] = OneVal;
    unique case (fin_w[1:0])
      ModeTranslate: begin
        out_d[288 +: 96] = fin_w[97:2];
      end
      ModeScale: begin
        out_d[0   +: 32] = fin_w[2  +: 32];
        out_d[128 +: 32] = fin_w[34 +: 32];
        out_d[256 +: 32] = fin_w[66 +: 32];
      end
      ModeRotate: begin
        for (int k = 0; k < 9; k++) out_d[32*k +: 32] = m_w[k];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end
  assign m_axis_tdata = out_q;

  logic unused_w;
  assign unused_w = ^pass_q[D-1];

  // A stalled result must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // The pipeline advances only when the output side allows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (m_axis_tready || !m_axis_tvalid))
    else $error("input ready inconsistent with output state");
  // A valid item in the stage before the output reaches the output when the pipeline advances.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[D-2] |=> m_axis_tvalid)
    else $error("item lost at output stage");

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// Affine transform matrix builder testbench
// Streams translate, scale, rotate and unused-mode items into the block with
// bursty input and a stalling output side, and compares every matrix with an
// independent fixed-point CORDIC and matrix product computation.
// ----------------------------------------------------------------------------
module tb;
  import atmb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int NumRandom = 430;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] xv;
    logic signed [31:0] yv;
    logic signed [31:0] zv;
  } vec_item_t;

  typedef logic [11:0][31:0] matrix_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [1:0]   s_axis_tuser = '0;  // mode
  logic [95:0]  s_axis_tdata = '0;  // x, y, z from the lowest bit up
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [383:0] m_axis_tdata;       // r00..r22, trans_x, trans_y, trans_z

  affine_transform_matrix_builder_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  vec_item_t pending_items[$];
  matrix_t   expected_matrices[$];
  int        mismatch_count = 0;
  bit        failed = 1'b0;
  bit        in_acc = 1'b0;

  function automatic void cordic_sin_cos(input longint angle, output longint s_o,
                                         output longint c_o);
    longint prod, phase, resid, z, x, y, nx, c, s;
    int quad;
    prod  = angle * longint'(InvTwoPi);
    phase = (prod >> FracBits) & 64'hFFFF_FFFF;
    quad  = int'(phase >> 30);
    resid = phase & 64'h3FFF_FFFF;
    z = longint'((64'(resid) * 64'(PiQ30)) >> 31);
    x = longint'(GainQ30);
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(AtanTab[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(AtanTab[i]);
      end
      x = nx;
    end
    case (quad)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c_o = (c + (64'sd1 <<< (29 - FracBits))) >>> (30 - FracBits);
    s_o = (s + (64'sd1 <<< (29 - FracBits))) >>> (30 - FracBits);
  endfunction

  function automatic void mul3(input longint a[3][3], input longint b[3][3],
                               output longint r[3][3]);
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
        r[i][j] = (acc + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
      end
  endfunction

  function automatic matrix_t build_matrix(input vec_item_t it);
    longint m[3][3], rx[3][3], ry[3][3], rz[3][3], tmp[3][3];
    longint tr[3];
    longint sx, cx, sy, cy, sz, cz;
    matrix_t res;
    for (int i = 0; i < 3; i++) begin
      tr[i] = 0;
      for (int j = 0; j < 3; j++) begin
        m[i][j]  = (i == j) ? (64'sd1 <<< FracBits) : 0;
        rx[i][j] = m[i][j];
        ry[i][j] = m[i][j];
        rz[i][j] = m[i][j];
      end
    end
    case (it.mode)
      ModeTranslate: begin
        tr[0] = it.xv; tr[1] = it.yv; tr[2] = it.zv;
      end
      ModeScale: begin
        m[0][0] = it.xv; m[1][1] = it.yv; m[2][2] = it.zv;
      end
      ModeRotate: begin
        cordic_sin_cos(it.xv, sx, cx);
        cordic_sin_cos(it.yv, sy, cy);
        cordic_sin_cos(it.zv, sz, cz);
        rx[1][1] = cx; rx[1][2] = sx; rx[2][1] = -sx; rx[2][2] = cx;
        ry[0][0] = cy; ry[0][2] = -sy; ry[2][0] = sy; ry[2][2] = cy;
        rz[0][0] = cz; rz[0][1] = sz; rz[1][0] = -sz; rz[1][1] = cz;
        mul3(rx, ry, tmp);
        mul3(tmp, rz, m);
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) res[i*3+j] = m[i][j][31:0];
    for (int i = 0; i < 3; i++) res[9+i] = tr[i][31:0];
    return res;
  endfunction

  // Acceptance and result checking both happen on the rising edge.
  always @(posedge clk_i) begin
    matrix_t want;
    matrix_t got;
    in_acc = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_acc) begin
      expected_matrices.push_back(build_matrix(pending_items[0]));
      void'(pending_items.pop_front());
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_matrices.size() == 0) begin
        failed = 1'b1;
        if (mismatch_count < 10) $display("Unexpected matrix %h", got);
        mismatch_count++;
      end else begin
        want = expected_matrices.pop_front();
        for (int f = 0; f < 12; f++)
          if (got[f] !== want[f]) begin
            failed = 1'b1;
            if (mismatch_count < 10)
              $display("Entry %0d: expected %h, got %h", f, want[f], got[f]);
            mismatch_count++;
          end
      end
    end
  end

  // Sender: bursts of random length separated by random gaps. An offered
  // transaction stays on the bus until it is accepted.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    vec_item_t nxt;
    if (rst_ni && !(s_axis_tvalid && !in_acc)) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        nxt = pending_items[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nxt.zv, nxt.yv, nxt.xv};
        s_axis_tuser  <= nxt.mode;
        if (burst_left <= 0) begin
          burst_left <= $urandom_range(40, 1);
          gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: its stall density is redrawn whenever its phase counter wraps.
  int ready_phase = 0;
  int stall_pct = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (ready_phase == 0) stall_pct <= $urandom_range(3, 0) * 25;
      ready_phase <= (ready_phase + 1) % 64;
      m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(3, 0))
      0: return $urandom();
      1: return $urandom_range(32'h0000_FFFF, 0) - 32'h0000_8000;
      default: return $urandom_range(32'h000C_0000, 0) - 32'h0006_0000;
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[6];
    vec_item_t it;
    edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000,
                  32'hFFFF_FFFF, 32'h0003_243F};
    for (int k = 0; k < 6; k++) begin
      pending_items.push_back('{ModeTranslate, edge_vals[k], edge_vals[(k+1)%6],
                                edge_vals[(k+2)%6]});
      pending_items.push_back('{ModeScale, edge_vals[(k+3)%6], edge_vals[k],
                                edge_vals[(k+4)%6]});
      pending_items.push_back('{ModeRotate, edge_vals[k], edge_vals[(k+5)%6],
                                edge_vals[(k+2)%6]});
    end
    // Quarter-turn boundaries, a large angle that wraps, and the unused mode.
    pending_items.push_back('{ModeRotate, 32'h0001_921F, 32'h0003_243F, 32'h0004_B65F});
    pending_items.push_back('{ModeRotate, 32'h0100_0000, 32'hFF00_0000, 32'h0});
    pending_items.push_back('{ModeUnused, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF});
    for (int n = 0; n < NumRandom; n++) begin
      it.mode = $urandom_range(9, 0) == 0 ? ModeUnused : 2'($urandom_range(2, 0));
      if (it.mode == ModeRotate) begin
        it.xv = rand_angle(); it.yv = rand_angle(); it.zv = rand_angle();
      end else begin
        it.xv = $urandom(); it.yv = $urandom(); it.zv = $urandom();
      end
      pending_items.push_back(it);
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_items.size() == 0 && expected_matrices.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed && expected_matrices.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

/* files.f */
rtl/core/atmb_pkg.sv
rtl/core/affine_transform_matrix_builder_unit.sv
tb/sv/tb.sv
